@@ hdl/rqeb_pkg.sv @@
package rqeb_pkg;

  // Table size and result limits.
  localparam int unsigned SLOTS_DEF   = 8;
  localparam int unsigned MAX_RES     = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_RES + 1);
  localparam int unsigned BACKOFF_CAP = 4;
  localparam int unsigned SHIFT_W     = $clog2(BACKOFF_CAP + 1);
  localparam int unsigned BACKOFF_W   = 16 + BACKOFF_CAP;
  localparam int unsigned OCC_W       = 4;
  localparam int unsigned OCC_MAX     = 15;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RETRY   = 1'b1;
  localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd5;
  localparam logic [15:0] BASE_RETRY_RST   = 16'd500;

  typedef enum logic [1:0] {
    FUNC_ENQ    = 2'd0,
    FUNC_SCAN   = 2'd1,
    FUNC_REPORT = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OUTC_ACCEPTED  = 2'd0,
    OUTC_DUPLICATE = 2'd1,
    OUTC_REJECTED  = 2'd2,
    OUTC_RETRY     = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_READ,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  cmd_type;
    logic [31:0] seq_number;
    logic [31:0] origin_ms;
    logic [31:0] now_ms;
    logic [2:0]  slot_index;
    logic [1:0]  outcome;
  } in_item_t;

  typedef struct packed {
    logic        enq_ok;
    logic        due_valid;
    logic [2:0]  due_slot;
    logic [3:0]  due_type;
    logic [31:0] due_seq;
    logic [31:0] due_origin_ms;
    logic        removed;
    logic        exhausted;
    logic [3:0]  occupancy;
    logic        last;
  } out_item_t;

  // One slot of the command table.
  typedef struct packed {
    logic [3:0]  cmd_type;
    logic [31:0] seq;
    logic [31:0] origin_ms;
    logic [7:0]  tries;
    logic [31:0] next_ms;
  } entry_t;

  typedef struct packed {
    logic start;
    logic step;
    logic read;
    logic commit;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       walk_end;
    logic       out_free;
    logic [1:0] req_func;
  } ctrl_sts_t;

endpackage

@@ hdl/retry_queue_exponential_backoff.sv @@
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o     rqeb_pkg::in_item_t  (in_data_i)
// out      output     out_valid_o/out_stall_i   rqeb_pkg::out_item_t (out_data_o)
// cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// An enqueue or a scan walks the slot store through its single read port, one slot a
// cycle while no due result is held back by an output stall; an enqueue then commits.
// A report reads and commits its one slot; a no-operation goes straight to its result.
// Reset empties the table at once and restores the register defaults; no clearing pass.
// The next item is taken while the last result still waits in the output register.
module retry_queue_exponential_backoff #(
  parameter int unsigned SLOTS = rqeb_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rqeb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rqeb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rqeb_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rqeb_pkg::out_item_t             out_data_o
);
  import rqeb_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  rqeb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Slot table, walk and result logic.
  rqeb_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // Once a transfer is taken the block works on it and takes no other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // Only a scan gives results that are not the last of their item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> out_data_o.due_valid)
    else $error("non-final result without a due entry");

  // A due entry carries no enqueue or report flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.due_valid) |->
      (!out_data_o.enq_ok && !out_data_o.removed && !out_data_o.exhausted))
    else $error("due entry mixed with other flags");

  // An exhausted entry is always removed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.exhausted) |-> out_data_o.removed)
    else $error("exhausted without removal");
`endif

endmodule

@@ hdl/rqeb_ctrl.sv @@
module rqeb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_func_i,
  input  rqeb_pkg::ctrl_sts_t  sts_i,
  output rqeb_pkg::ctrl_cmd_t  cmd_o,
  output logic                 in_stall_o
);
  import rqeb_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_func_i)
            FUNC_ENQ:    state_d = ST_WALK;
            FUNC_SCAN:   state_d = ST_WALK;
            FUNC_REPORT: state_d = ST_READ;
            default:     state_d = ST_FINISH;
          endcase
        end
      end
      ST_WALK: begin
        if (sts_i.walk_end) begin
          state_d = (sts_i.req_func == FUNC_ENQ) ? ST_COMMIT : ST_FINISH;
        end
      end
      ST_READ:   state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_FINISH;
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.start = in_valid_i;
      end
      ST_WALK:   cmd_o.step   = 1'b1;
      ST_READ:   cmd_o.read   = 1'b1;
      ST_COMMIT: cmd_o.commit = 1'b1;
      ST_FINISH: cmd_o.finish = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

@@ hdl/rqeb_datapath.sv @@
module rqeb_datapath #(
  parameter int unsigned SLOTS = rqeb_pkg::SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rqeb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rqeb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  rqeb_pkg::in_item_t                 in_data_i,
  input  rqeb_pkg::ctrl_cmd_t                cmd_i,
  output rqeb_pkg::ctrl_sts_t                sts_o,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output rqeb_pkg::out_item_t                out_data_o
);
  import rqeb_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned IW = (CW > 3) ? CW : 3;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  // Configuration registers.
  logic [7:0]  max_att_q;
  logic [15:0] base_q;

  // Request and table state.
  in_item_t         req_q;
  logic [SLOTS-1:0] busy_q;
  logic [CW-1:0]    occ_q;
  entry_t           slot_mem_q [SLOTS];

  // Walk pipeline: pointer, registered read data and its slot.
  logic [CW-1:0] ptr_q;
  entry_t        ent_q;
  logic [AW-1:0] eidx_q;
  logic          evalid_q;
  logic          rep_ok_q;

  // Per-item results.
  logic             dup_q;
  logic             free_found_q;
  logic [AW-1:0]    free_idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pend_valid_q;
  entry_t           pend_q;
  logic [AW-1:0]    pend_idx_q;
  logic             removed_q;
  logic             exhausted_q;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  logic                 is_enq, is_scan, cur_busy;
  logic                 due_hit, out_free, blocked, step_go, rd_en;
  logic                 mid_push, fin_push, push, walk_end;
  logic [IW-1:0]        idx_w;
  logic                 in_range;
  logic [7:0]           tries_new;
  logic [SHIFT_W-1:0]   sh;
  logic [BACKOFF_W-1:0] backoff;
  logic [31:0]          next_ms;
  logic                 rep_hit, rep_retry, rep_exh, rep_remove, enq_write;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  entry_t               wr_data;
  logic [OCC_W-1:0]     occ_out;
  out_item_t            res;

  // Decode and walk control.
  always_comb begin
    is_enq   = (req_q.func == FUNC_ENQ);
    is_scan  = (req_q.func == FUNC_SCAN);
    cur_busy = busy_q[eidx_q];
    out_free = !out_valid_q || !out_stall_i;
    due_hit  = cmd_i.step && evalid_q && is_scan && cur_busy &&
               (req_q.now_ms >= ent_q.next_ms) && (cnt_q != CNT_W'(MAX_RES));
    blocked  = due_hit && pend_valid_q && !out_free;
    step_go  = cmd_i.step && !blocked;
    rd_en    = cmd_i.read || (step_go && (ptr_q < SLOTS_C));
    mid_push = due_hit && pend_valid_q && out_free;
    fin_push = cmd_i.finish && out_free;
    push     = mid_push || fin_push;
    walk_end = (!evalid_q && (ptr_q == SLOTS_C)) ||
               (is_scan && (cnt_q == CNT_W'(MAX_RES)));
    idx_w    = IW'(in_data_i.slot_index);
    in_range = (idx_w < IW'(SLOTS));
  end

  // Report outcome: attempt count and backoff time.
  always_comb begin
    tries_new  = ent_q.tries + 8'd1;
    sh         = (tries_new > 8'(BACKOFF_CAP)) ? SHIFT_W'(BACKOFF_CAP)
                                               : SHIFT_W'(tries_new);
    backoff    = BACKOFF_W'(base_q) << sh;
    next_ms    = req_q.now_ms + 32'(backoff);
    rep_hit    = rep_ok_q && (req_q.func == FUNC_REPORT) && busy_q[eidx_q];
    rep_retry  = (req_q.outcome == OUTC_RETRY);
    rep_exh    = rep_retry && (tries_new >= max_att_q);
    rep_remove = rep_hit && (!rep_retry || rep_exh);
    enq_write  = is_enq && !dup_q && free_found_q;
  end

  // Slot store write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_idx_q;
    wr_data = ent_q;
    if (cmd_i.commit) begin
      if (enq_write) begin
        wr_en             = 1'b1;
        wr_addr           = free_idx_q;
        wr_data.cmd_type  = req_q.cmd_type;
        wr_data.seq       = req_q.seq_number;
        wr_data.origin_ms = req_q.origin_ms;
        wr_data.tries     = 8'd0;
        wr_data.next_ms   = req_q.now_ms;
      end else if (rep_hit && !rep_remove) begin
        wr_en           = 1'b1;
        wr_addr         = eidx_q;
        wr_data.tries   = tries_new;
        wr_data.next_ms = next_ms;
      end
    end
  end

  // Slot store, registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ent_q  <= slot_mem_q[ptr_q[AW-1:0]];
      eidx_q <= ptr_q[AW-1:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q <= MAX_ATTEMPTS_RST;
      base_q    <= BASE_RETRY_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MAX_ATTEMPTS) begin
        max_att_q <= cfg_wdata_i[7:0];
      end
      if (cfg_idx_i == REG_BASE_RETRY) begin
        base_q <= cfg_wdata_i[15:0];
      end
    end
  end

  // Occupancy flags and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      occ_q  <= '0;
    end else if (cmd_i.commit) begin
      if (enq_write) begin
        busy_q[free_idx_q] <= 1'b1;
        occ_q              <= occ_q + CW'(1);
      end else if (rep_remove) begin
        busy_q[eidx_q] <= 1'b0;
        occ_q          <= occ_q - CW'(1);
      end
    end
  end

  // Request capture and walk pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      evalid_q <= 1'b0;
      rep_ok_q <= 1'b0;
    end else if (cmd_i.start) begin
      ptr_q    <= ((in_data_i.func == FUNC_REPORT) && in_range) ? CW'(idx_w) : '0;
      evalid_q <= 1'b0;
      rep_ok_q <= in_range;
    end else if (step_go) begin
      evalid_q <= (ptr_q < SLOTS_C);
      if (ptr_q < SLOTS_C) begin
        ptr_q <= ptr_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= in_data_i;
    end
  end

  // Walk evaluation: duplicate and free slot search, due entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      removed_q    <= 1'b0;
      exhausted_q  <= 1'b0;
    end else if (cmd_i.start) begin
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      removed_q    <= 1'b0;
      exhausted_q  <= 1'b0;
    end else begin
      if (step_go && evalid_q && is_enq) begin
        if (cur_busy && (ent_q.seq == req_q.seq_number)) begin
          dup_q <= 1'b1;
        end
        if (!cur_busy && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (due_hit && !blocked) begin
        pend_valid_q <= 1'b1;
        cnt_q        <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.commit && rep_remove) begin
        removed_q   <= 1'b1;
        exhausted_q <= rep_exh;
      end
    end
  end

  // Payload of the walk results.
  always_ff @(posedge clk_i) begin
    if (step_go && evalid_q && is_enq && !cur_busy && !free_found_q) begin
      free_idx_q <= eidx_q;
    end
    if (due_hit && !blocked) begin
      pend_q     <= ent_q;
      pend_idx_q <= eidx_q;
    end
  end

  // Result formation.
  always_comb begin
    occ_out = (32'(occ_q) > OCC_MAX) ? OCC_W'(OCC_MAX) : OCC_W'(occ_q);
    res           = '0;
    res.occupancy = occ_out;
    if (mid_push) begin
      res.due_valid     = 1'b1;
      res.due_slot      = 3'(pend_idx_q);
      res.due_type      = pend_q.cmd_type;
      res.due_seq       = pend_q.seq;
      res.due_origin_ms = pend_q.origin_ms;
    end else begin
      res.last = 1'b1;
      case (req_q.func)
        FUNC_ENQ: res.enq_ok = dup_q || free_found_q;
        FUNC_SCAN: begin
          if (pend_valid_q) begin
            res.due_valid     = 1'b1;
            res.due_slot      = 3'(pend_idx_q);
            res.due_type      = pend_q.cmd_type;
            res.due_seq       = pend_q.seq;
            res.due_origin_ms = pend_q.origin_ms;
          end
        end
        FUNC_REPORT: begin
          res.removed   = removed_q;
          res.exhausted = exhausted_q;
        end
        default: res.last = 1'b1;
      endcase
    end
  end

  // Output register: a result waits here while the walk goes on.
  always_comb begin
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.walk_end  = walk_end;
  assign sts_o.out_free  = out_free;
  assign sts_o.req_func  = req_q.func;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rqeb_pkg::*;

  localparam int NUM_SLOTS = SLOTS_DEF;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;

  retry_queue_exponential_backoff #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Mirror of the command table and of the two registers.
  logic       busy [NUM_SLOTS];
  entry_t     tab  [NUM_SLOTS];
  logic [7:0]  max_att    = MAX_ATTEMPTS_RST;
  logic [15:0] base_retry = BASE_RETRY_RST;

  // Replies still owed by the block, oldest first.
  out_item_t replies_q[$];
  int        bad_replies = 0;

  // Stimulus state: the simulated wall clock and the idling controls.
  logic [31:0] wall_ms = '0;
  bit          quiet = 1'b0;
  bit          pause_mode = 1'b0;
  int          sent_count = 0;

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      busy[s] = 1'b0;
      tab[s]  = '0;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A generous ceiling on the whole run.
  initial begin
    #5_000_000;
    $display("retry_queue_exponential_backoff verification failed");
    $finish;
  end

  function automatic logic [3:0] count_busy();
    int n;
    n = 0;
    for (int s = 0; s < NUM_SLOTS; s++)
      if (busy[s]) n++;
    return (n > OCC_MAX) ? 4'(OCC_MAX) : 4'(n);
  endfunction

  function automatic int random_busy_slot();
    int first;
    first = $urandom_range(0, NUM_SLOTS - 1);
    for (int k = 0; k < NUM_SLOTS; k++)
      if (busy[(first + k) % NUM_SLOTS]) return (first + k) % NUM_SLOTS;
    return -1;
  endfunction

  // Applies one accepted command to the mirror and queues the replies it owes.
  function automatic void apply_command(in_item_t it);
    out_item_t r;
    logic      hit;
    logic [3:0] occ;
    int        n_due;
    int        k;
    int        shift;
    r = '0;
    case (it.func)
      FUNC_ENQ: begin
        hit = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++)
          if (busy[s] && tab[s].seq == it.seq_number) hit = 1'b1;
        if (!hit) begin
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!hit && !busy[s]) begin
              busy[s]          = 1'b1;
              tab[s].cmd_type  = it.cmd_type;
              tab[s].seq       = it.seq_number;
              tab[s].origin_ms = it.origin_ms;
              tab[s].tries     = '0;
              tab[s].next_ms   = it.now_ms;
              hit              = 1'b1;
            end
          end
        end
        r.enq_ok    = hit;
        r.occupancy = count_busy();
        r.last      = 1'b1;
        replies_q.push_back(r);
      end
      FUNC_SCAN: begin
        occ   = count_busy();
        n_due = 0;
        for (int s = 0; s < NUM_SLOTS; s++)
          if (busy[s] && it.now_ms >= tab[s].next_ms) n_due++;
        if (n_due > MAX_RES) n_due = MAX_RES;
        if (n_due == 0) begin
          r.occupancy = occ;
          r.last      = 1'b1;
          replies_q.push_back(r);
        end else begin
          k = 0;
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (k < n_due && busy[s] && it.now_ms >= tab[s].next_ms) begin
              r               = '0;
              r.due_valid     = 1'b1;
              r.due_slot      = 3'(s);
              r.due_type      = tab[s].cmd_type;
              r.due_seq       = tab[s].seq;
              r.due_origin_ms = tab[s].origin_ms;
              r.occupancy     = occ;
              r.last          = (k == n_due - 1);
              replies_q.push_back(r);
              k++;
            end
          end
        end
      end
      FUNC_REPORT: begin
        if (busy[it.slot_index]) begin
          if (it.outcome != OUTC_RETRY) begin
            busy[it.slot_index] = 1'b0;
            r.removed = 1'b1;
          end else begin
            tab[it.slot_index].tries = tab[it.slot_index].tries + 8'd1;
            if (tab[it.slot_index].tries >= max_att) begin
              busy[it.slot_index] = 1'b0;
              r.removed   = 1'b1;
              r.exhausted = 1'b1;
            end else begin
              // The delay doubles with each failure, but only up to the cap.
              shift = (tab[it.slot_index].tries > BACKOFF_CAP) ?
                      BACKOFF_CAP : int'(tab[it.slot_index].tries);
              tab[it.slot_index].next_ms = it.now_ms + (32'(base_retry) << shift);
            end
          end
        end
        r.occupancy = count_busy();
        r.last      = 1'b1;
        replies_q.push_back(r);
      end
      default: begin
        r.occupancy = count_busy();
        r.last      = 1'b1;
        replies_q.push_back(r);
      end
    endcase
  endfunction

  function automatic string show_reply(out_item_t r);
    return $sformatf({"ok=%0b due=%0b slot=%0d type=%0d seq=%h origin=%h ",
                      "removed=%0b exhausted=%0b occ=%0d last=%0b"},
                     r.enq_ok, r.due_valid, r.due_slot, r.due_type, r.due_seq,
                     r.due_origin_ms, r.removed, r.exhausted, r.occupancy, r.last);
  endfunction

  function automatic void note_fault(string msg);
    bad_replies++;
    if (bad_replies <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  function automatic in_item_t cmd(func_e f, logic [3:0] ty, logic [31:0] seq,
                                   logic [31:0] origin, logic [31:0] now,
                                   logic [2:0] slot, outcome_e oc);
    in_item_t it;
    it.func       = f;
    it.cmd_type   = ty;
    it.seq_number = seq;
    it.origin_ms  = origin;
    it.now_ms     = now;
    it.slot_index = slot;
    it.outcome    = oc;
    return it;
  endfunction

  // Mostly well-formed traffic against the live table, with some noise.
  function automatic in_item_t pick_command();
    in_item_t it;
    int       roll;
    int       s;
    it.func       = FUNC_NOP;
    it.cmd_type   = 4'($urandom);
    it.seq_number = $urandom;
    it.origin_ms  = $urandom;
    it.now_ms     = wall_ms;
    it.slot_index = 3'($urandom);
    it.outcome    = 2'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      it.func = 2'($urandom);
      if ($urandom_range(0, 1) == 0) it.now_ms = $urandom;
    end else if (roll < 45) begin
      it.func = FUNC_ENQ;
      s = random_busy_slot();
      if (s >= 0 && $urandom_range(0, 3) == 0) it.seq_number = tab[s].seq;
    end else if (roll < 68) begin
      it.func = FUNC_SCAN;
    end else begin
      it.func = FUNC_REPORT;
      s = random_busy_slot();
      if (s >= 0) it.slot_index = 3'(s);
      if ($urandom_range(0, 1) == 0) begin
        it.outcome = OUTC_RETRY;
      end else begin
        it.outcome = 2'($urandom_range(0, 2));
      end
    end
    return it;
  endfunction

  // Offers one command, waits for its transfer, then perhaps idles for a burst.
  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    apply_command(it);
    sent_count++;
    if (sent_count % 16 == 0) pause_mode = ($urandom_range(0, 1) == 1);
    if (!quiet && pause_mode && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Holds off the sender until every owed reply has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (replies_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [7:0] attempts, logic [15:0] base);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MAX_ATTEMPTS;
    cfg_wdata_i <= {8'h00, attempts};
    @(posedge clk_i);
    cfg_idx_i   <= REG_BASE_RETRY;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_att    = attempts;
    base_retry = base;
  endtask

  task automatic run_traffic(int target);
    in_item_t it;
    int       done;
    done = 0;
    while (done < target) begin
      if ($urandom_range(0, 2) == 0) wall_ms += $urandom_range(0, 20 * base_retry);
      it = pick_command();
      if (!(it.func == FUNC_NOP || (it.func == FUNC_REPORT && !busy[it.slot_index])))
        done++;
      send_item(it);
      if ($urandom_range(0, 79) == 0) drain();
    end
  endtask

  // Hand-picked sequence under the reset register values.
  task automatic test_directed();
    send_item(cmd(FUNC_SCAN, 4'h0, 32'h0, 32'h0, 32'h0, 3'd0, OUTC_ACCEPTED));
    send_item(cmd(FUNC_NOP, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7,
                  OUTC_RETRY));
    // Fill the table; the last entry becomes due later than the rest.
    send_item(cmd(FUNC_ENQ, 4'h0, 32'h0000_0000, 32'h0000_0000, 32'd100, 3'd0,
                  OUTC_ACCEPTED));
    send_item(cmd(FUNC_ENQ, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100, 3'd0,
                  OUTC_ACCEPTED));
    for (int s = 2; s < 7; s++)
      send_item(cmd(FUNC_ENQ, 4'(s), 32'(s * 32'h1111_1111), 32'(s * 7), 32'd100, 3'd0,
                    OUTC_ACCEPTED));
    send_item(cmd(FUNC_ENQ, 4'hA, 32'h8000_0000, 32'h8000_0001, 32'd200, 3'd0,
                  OUTC_ACCEPTED));
    // A known sequence is accepted even when full; a new one is refused.
    send_item(cmd(FUNC_ENQ, 4'h3, 32'hFFFF_FFFF, 32'h0, 32'd120, 3'd0, OUTC_ACCEPTED));
    send_item(cmd(FUNC_ENQ, 4'h3, 32'h1234_5678, 32'h0, 32'd120, 3'd0, OUTC_ACCEPTED));
    send_item(cmd(FUNC_SCAN, 4'h0, 32'h0, 32'h0, 32'd150, 3'd0, OUTC_ACCEPTED));
    send_item(cmd(FUNC_SCAN, 4'h0, 32'h0, 32'h0, 32'd200, 3'd0, OUTC_ACCEPTED));
    // Two failures on one slot, the second before it is due again.
    send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd200, 3'd3, OUTC_RETRY));
    send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd300, 3'd3, OUTC_RETRY));
    send_item(cmd(FUNC_SCAN, 4'h0, 32'h0, 32'h0, 32'd1000, 3'd0, OUTC_ACCEPTED));
    send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd1000, 3'd0, OUTC_ACCEPTED));
    send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd1000, 3'd1, OUTC_DUPLICATE));
    send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd1000, 3'd2, OUTC_REJECTED));
    // A report on a free slot changes nothing.
    send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd1000, 3'd1, OUTC_RETRY));
    send_item(cmd(FUNC_ENQ, 4'h9, 32'h0BAD_CAFE, 32'h55, 32'd1500, 3'd0, OUTC_ACCEPTED));
    send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd1500, 3'd7, OUTC_RETRY));
    send_item(cmd(FUNC_SCAN, 4'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 3'd0, OUTC_ACCEPTED));
  endtask

  // Register extremes, the backoff cap, wrap of the next time and exhaustion.
  task automatic test_backoff_exhaustion();
    for (int s = 0; s < NUM_SLOTS; s++)
      if (busy[s])
        send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd0, 3'(s), outcome_e'(s % 3)));
    // A zero limit drops an entry on its first failure.
    write_regs(8'd0, 16'hFFFF);
    send_item(cmd(FUNC_ENQ, 4'h5, 32'hA5A5_0001, 32'h1, 32'h10, 3'd0, OUTC_ACCEPTED));
    send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'h10, 3'd0, OUTC_RETRY));
    // Seven attempts near the top of the clock: the next time wraps past zero.
    write_regs(8'd7, 16'hFFFF);
    send_item(cmd(FUNC_ENQ, 4'h6, 32'hA5A5_0002, 32'h2, 32'hFFFF_0000, 3'd0,
                  OUTC_ACCEPTED));
    for (int k = 0; k < 7; k++) begin
      send_item(cmd(FUNC_SCAN, 4'h0, 32'h0, 32'h0, 32'hFFFF_0000 + k, 3'd0, OUTC_ACCEPTED));
      send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'hFFFF_0000 + k, 3'd0, OUTC_RETRY));
    end
    write_regs(8'd1, 16'd1);
    send_item(cmd(FUNC_ENQ, 4'h7, 32'hA5A5_0003, 32'h3, 32'd5, 3'd0, OUTC_ACCEPTED));
    send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd5, 3'd0, OUTC_RETRY));
    write_regs(8'd255, 16'd1);
    send_item(cmd(FUNC_ENQ, 4'h8, 32'hA5A5_0004, 32'h4, 32'd0, 3'd0, OUTC_ACCEPTED));
    for (int k = 0; k < 6; k++) begin
      send_item(cmd(FUNC_REPORT, 4'h0, 32'h0, 32'h0, 32'd0, 3'd0, OUTC_RETRY));
      send_item(cmd(FUNC_SCAN, 4'h0, 32'h0, 32'h0, 32'd10, 3'd0, OUTC_ACCEPTED));
    end
  endtask

  // Random traffic over several register settings.
  task automatic test_random_traffic();
    write_regs(8'd255, 16'hFFFF);
    wall_ms = $urandom;
    run_traffic(32);
    write_regs(8'd1, 16'd1);
    wall_ms = '0;
    run_traffic(32);
    write_regs(8'($urandom_range(2, 8)), 16'($urandom_range(1, 4000)));
    wall_ms = $urandom;
    run_traffic(32);
    write_regs(8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)));
    run_traffic(32);
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_calm_tail();
    write_regs(MAX_ATTEMPTS_RST, BASE_RETRY_RST);
    quiet = 1'b1;
    run_traffic(24);
  endtask

  // Receiver: stall in random bursts, with free-running stretches between.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 2) != 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Each result transfer is checked against the oldest owed reply.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_q.size() == 0) begin
        note_fault($sformatf("unexpected result: %s", show_reply(out_data_o)));
      end else begin
        want = replies_q.pop_front();
        if (out_data_o.enq_ok !== want.enq_ok ||
            out_data_o.due_valid !== want.due_valid ||
            out_data_o.due_slot !== want.due_slot ||
            out_data_o.due_type !== want.due_type ||
            out_data_o.due_seq !== want.due_seq ||
            out_data_o.due_origin_ms !== want.due_origin_ms ||
            out_data_o.removed !== want.removed ||
            out_data_o.exhausted !== want.exhausted ||
            out_data_o.occupancy !== want.occupancy ||
            out_data_o.last !== want.last) begin
          note_fault($sformatf("mismatch\n  expected %s\n  actual   %s",
                               show_reply(want), show_reply(out_data_o)));
        end
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backoff_exhaustion();
    test_random_traffic();
    test_calm_tail();
    drain();
    repeat (40) @(posedge clk_i);
    if (replies_q.size() != 0)
      note_fault($sformatf("%0d results never arrived", replies_q.size()));
    if (bad_replies == 0) begin
      $display("retry_queue_exponential_backoff verification clean");
    end else begin
      $display("retry_queue_exponential_backoff verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rqeb_pkg.sv
hdl/rqeb_ctrl.sv
hdl/rqeb_datapath.sv
hdl/retry_queue_exponential_backoff.sv
verif/tb_top.sv
